>>> rtl/core/owvsr_pkg.sv
// Shared types, constants and register indexes of the omni wheel velocity to step rate block.
`default_nettype none
package owvsr_pkg;

    localparam int TIMER_HZ_DEF  = 312500;
    localparam int VEL_FRAC_DEF  = 12;
    localparam int COS30_Q16     = 56756;
    localparam int NUM_WHEELS    = 3;
    // Surface speed width (signed) and its magnitude width.
    localparam int S_W           = 34;
    localparam int MAG_W         = 33;
    // Shared divider width, covers |s| * ticks_per_radian.
    localparam int DIV_W         = 49;
    localparam int MUL_A_W       = 24;
    localparam int MUL_B_W       = 17;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int ACC_W         = 2 * MUL_A_W + MUL_B_W + 1;
    localparam int Q_DEPTH       = 2;

    typedef enum logic [2:0] {
        REG_HUB_DIST,
        REG_TIRE_RAD,
        REG_TICKS_PER_RADIAN,
        REG_RATE_LIMIT,
        REG_RATE_FLOOR,
        REG_ADDR_FRONT,
        REG_ADDR_LEFT,
        REG_ADDR_RIGHT
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] hub_dist;
        logic [15:0] tire_rad;
        logic [15:0] ticks_per_radian;
        logic [15:0] rate_limit;
        logic [15:0] rate_floor;
        logic [7:0]  addr_front;
        logic [7:0]  addr_left;
        logic [7:0]  addr_right;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        hub_dist:         16'd9830,
        tire_rad:         16'd2621,
        ticks_per_radian: 16'd8149,
        rate_limit:       16'd2000,
        rate_floor:       16'd10,
        addr_front:       8'd1,
        addr_left:        8'd2,
        addr_right:       8'd3
    };

    // One classified command: three wheel surface speeds and the body velocities.
    typedef struct packed {
        logic [NUM_WHEELS-1:0][S_W-1:0] s;
        logic [15:0]                    vf;
        logic [15:0]                    vl;
        logic [15:0]                    tr;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MLO,
        ST_MHI,
        ST_ACC,
        ST_POST,
        ST_DIV,
        ST_KDIV,
        ST_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        PH_RATE,
        PH_SCALE,
        PH_VEL
    } phase_t;

endpackage
`default_nettype wire

>>> rtl/core/owvsr_front.sv
// Front stage: takes commands and forms the three wheel surface speeds.
`default_nettype none
module owvsr_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire owvsr_pkg::cfg_t    cfg,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [15:0]        s_vel_forward,
    input  wire logic [15:0]        s_vel_left,
    input  wire logic [15:0]        s_turn_rate,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output owvsr_pkg::cmd_t         push_data
);
    localparam int SW = owvsr_pkg::S_W;

    logic               v1_reg;
    logic signed [32:0] rot_reg;
    logic signed [32:0] c_reg;
    logic [15:0]        vf_reg;
    logic [15:0]        vl_reg;
    logic [15:0]        tr_reg;

    logic signed [SW-1:0] rot_x;
    logic signed [SW-1:0] c_x;
    logic signed [SW-1:0] vl_x;

    assign s_ready = !v1_reg || push_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            rot_reg <= $signed(s_turn_rate) * $signed({1'b0, cfg.hub_dist});
            c_reg   <= $signed(s_vel_forward) * $signed(17'(owvsr_pkg::COS30_Q16));
            vf_reg  <= s_vel_forward;
            vl_reg  <= s_vel_left;
            tr_reg  <= s_turn_rate;
        end
    end

    assign rot_x = SW'(rot_reg);
    assign c_x   = SW'(c_reg);
    assign vl_x  = SW'($signed(vl_reg));

    assign push_valid   = v1_reg;
    assign push_data.s[0] = rot_x + (vl_x <<< 16);
    assign push_data.s[1] = rot_x - c_x - (vl_x <<< 15);
    assign push_data.s[2] = rot_x + c_x - (vl_x <<< 15);
    assign push_data.vf = vf_reg;
    assign push_data.vl = vl_reg;
    assign push_data.tr = tr_reg;

endmodule
`default_nettype wire

>>> rtl/core/owvsr_fifo.sv
// Short command queue between the front and back stages.
`default_nettype none
module owvsr_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire owvsr_pkg::cmd_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output owvsr_pkg::cmd_t      pop_data
);
    localparam int DEPTH = owvsr_pkg::Q_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    owvsr_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/owvsr_div.sv
// Restoring divider that resolves one quotient bit per cycle.
`default_nettype none
module owvsr_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [owvsr_pkg::DIV_W-1:0]   dividend,
    input  wire logic [owvsr_pkg::DIV_W-1:0]   divisor,
    output logic [owvsr_pkg::DIV_W-1:0]        quotient,
    output logic                               done
);
    localparam int DW = owvsr_pkg::DIV_W;
    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] dsr_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          qbit;

    assign rem_sh   = {rem_reg, quo_reg[DW-1]};
    assign diff     = rem_sh - {1'b0, dsr_reg};
    assign qbit     = (rem_sh >= {1'b0, dsr_reg});
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(DW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], qbit};
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/owvsr_back.sv
// Back stage: sequences wheel rates, overspeed scaling, step periods, scaled body velocities and results.
`default_nettype none
module owvsr_back #(
    parameter int TIMER_HZ      = owvsr_pkg::TIMER_HZ_DEF,
    parameter int VEL_FRAC_BITS = owvsr_pkg::VEL_FRAC_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire owvsr_pkg::cfg_t cfg,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire owvsr_pkg::cmd_t q_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [1:0]           m_wheel_index,
    output logic [7:0]           m_driver_address,
    output logic [15:0]          m_step_period,
    output logic                 m_forward_dir,
    output logic                 m_motor_on,
    output logic [15:0]          m_scaled_forward,
    output logic [15:0]          m_scaled_left,
    output logic [15:0]          m_scaled_turn,
    output logic                 m_last_wheel
);
    localparam int DW = owvsr_pkg::DIV_W;
    localparam int AW = owvsr_pkg::MUL_A_W;
    localparam int BW = owvsr_pkg::MUL_B_W;
    localparam int PW = owvsr_pkg::PROD_W;
    localparam int XW = owvsr_pkg::ACC_W;
    localparam int SW = owvsr_pkg::S_W;
    localparam int MW = owvsr_pkg::MAG_W;
    localparam logic [DW-1:0] PER_NUM = DW'(TIMER_HZ) << 8;

    owvsr_pkg::back_state_t state_reg, state_next;
    owvsr_pkg::phase_t      phase_reg;
    owvsr_pkg::cmd_t        cmd_reg;
    logic [1:0]             idx_reg;
    logic [2*AW-1:0]        opa_reg;
    logic [PW-1:0]          prod_reg;
    logic [XW-1:0]          acc_reg;
    logic [DW-1:0]          m_reg [3];
    logic [DW-1:0]          maxm_reg;
    logic [BW-1:0]          k_reg;
    logic [15:0]            per_reg [3];
    logic [2:0]             dir_reg;
    logic [2:0]             on_reg;
    logic [15:0]            vel_reg [3];

    logic [15:0]            ob_per_reg [3];
    logic [2:0]             ob_dir_reg;
    logic [2:0]             ob_on_reg;
    logic [15:0]            ob_vel_reg [3];
    logic                   ob_busy_reg;
    logic [1:0]             ob_cnt_reg;

    logic                   advance;
    logic                   last;
    logic                   div_start;
    logic [DW-1:0]          div_dvd;
    logic [DW-1:0]          div_dsr;
    logic [DW-1:0]          div_q;
    logic                   div_done;
    logic signed [SW-1:0]   s_cur;
    logic [SW-1:0]          s_neg;
    logic [MW-1:0]          s_abs;
    logic [15:0]            v_cur;
    logic [15:0]            v_abs;
    logic [15:0]            v_mag;
    logic [BW-1:0]          b_op;
    logic [23:0]            ms;
    logic                   ms_zero;
    logic [DW-1:0]          maxm_new;
    logic                   overspeed;
    logic [15:0]            wr_eff;
    logic [15:0]            per_sat;

    owvsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (div_q),
        .done     (div_done)
    );

    assign q_ready = (state_reg == owvsr_pkg::ST_IDLE);
    assign last    = (idx_reg == 2'd2);
    assign s_cur   = $signed(cmd_reg.s[idx_reg]);
    assign s_neg   = -s_cur;
    assign s_abs   = s_cur[SW-1] ? s_neg[MW-1:0] : s_cur[MW-1:0];

    always_comb begin
        case (idx_reg)
            2'd0:    v_cur = cmd_reg.vf;
            2'd1:    v_cur = cmd_reg.vl;
            default: v_cur = cmd_reg.tr;
        endcase
    end

    assign v_abs     = v_cur[15] ? (~v_cur + 16'd1) : v_cur;
    assign v_mag     = acc_reg[31:16];
    assign b_op      = (phase_reg == owvsr_pkg::PH_RATE) ? BW'(cfg.ticks_per_radian) : k_reg;
    assign ms        = acc_reg[39:16];
    assign ms_zero   = (ms == '0);
    assign maxm_new  = (div_q > maxm_reg) ? div_q : maxm_reg;
    assign overspeed = (maxm_new > DW'({cfg.rate_limit, 8'h00}));
    assign wr_eff    = (cfg.tire_rad == '0) ? 16'd1 : cfg.tire_rad;
    assign per_sat   = (div_q[DW-1:16] != '0) ? 16'hFFFF : div_q[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= owvsr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        advance    = 1'b0;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dsr    = '0;
        case (state_reg)
            owvsr_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = owvsr_pkg::ST_LOAD;
                end
            end
            owvsr_pkg::ST_LOAD: state_next = owvsr_pkg::ST_MLO;
            owvsr_pkg::ST_MLO:  state_next = owvsr_pkg::ST_MHI;
            owvsr_pkg::ST_MHI:  state_next = owvsr_pkg::ST_ACC;
            owvsr_pkg::ST_ACC:  state_next = owvsr_pkg::ST_POST;
            owvsr_pkg::ST_POST: begin
                case (phase_reg)
                    owvsr_pkg::PH_RATE: begin
                        div_start  = 1'b1;
                        div_dvd    = acc_reg[DW-1:0] >> VEL_FRAC_BITS;
                        div_dsr    = DW'(wr_eff);
                        state_next = owvsr_pkg::ST_DIV;
                    end
                    owvsr_pkg::PH_SCALE: begin
                        if (ms_zero) begin
                            advance = 1'b1;
                        end else begin
                            div_start  = 1'b1;
                            div_dvd    = PER_NUM;
                            div_dsr    = DW'(ms);
                            state_next = owvsr_pkg::ST_DIV;
                        end
                    end
                    default: advance = 1'b1;
                endcase
            end
            owvsr_pkg::ST_DIV: begin
                if (div_done) begin
                    advance = 1'b1;
                end
            end
            owvsr_pkg::ST_KDIV: begin
                if (div_done) begin
                    state_next = owvsr_pkg::ST_LOAD;
                end
            end
            owvsr_pkg::ST_DONE: begin
                if (!ob_busy_reg) begin
                    state_next = owvsr_pkg::ST_IDLE;
                end
            end
            default: state_next = owvsr_pkg::ST_IDLE;
        endcase
        if (advance) begin
            if (!last) begin
                state_next = owvsr_pkg::ST_LOAD;
            end else begin
                case (phase_reg)
                    owvsr_pkg::PH_RATE: begin
                        if (overspeed) begin
                            state_next = owvsr_pkg::ST_KDIV;
                            div_start  = 1'b1;
                            div_dvd    = DW'({cfg.rate_limit, 24'h000000});
                            div_dsr    = maxm_new;
                        end else begin
                            state_next = owvsr_pkg::ST_LOAD;
                        end
                    end
                    owvsr_pkg::PH_SCALE: state_next = owvsr_pkg::ST_LOAD;
                    default:             state_next = owvsr_pkg::ST_DONE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= owvsr_pkg::PH_RATE;
            idx_reg   <= '0;
        end else begin
            if (state_reg == owvsr_pkg::ST_IDLE) begin
                phase_reg <= owvsr_pkg::PH_RATE;
                idx_reg   <= '0;
            end else if (advance) begin
                if (!last) begin
                    idx_reg <= idx_reg + 2'd1;
                end else begin
                    idx_reg <= '0;
                    case (phase_reg)
                        owvsr_pkg::PH_RATE:  phase_reg <= owvsr_pkg::PH_SCALE;
                        owvsr_pkg::PH_SCALE: phase_reg <= owvsr_pkg::PH_VEL;
                        default:             phase_reg <= owvsr_pkg::PH_RATE;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            owvsr_pkg::ST_IDLE: begin
                if (q_valid) begin
                    cmd_reg  <= q_data;
                    maxm_reg <= '0;
                    k_reg    <= BW'(1) << 16;
                end
            end
            owvsr_pkg::ST_LOAD: begin
                case (phase_reg)
                    owvsr_pkg::PH_RATE:  opa_reg <= (2*AW)'(s_abs);
                    owvsr_pkg::PH_SCALE: opa_reg <= m_reg[idx_reg][2*AW-1:0];
                    default:             opa_reg <= (2*AW)'(v_abs);
                endcase
            end
            owvsr_pkg::ST_MLO: begin
                prod_reg <= opa_reg[AW-1:0] * b_op;
            end
            owvsr_pkg::ST_MHI: begin
                acc_reg  <= XW'(prod_reg);
                prod_reg <= opa_reg[2*AW-1:AW] * b_op;
            end
            owvsr_pkg::ST_ACC: begin
                acc_reg <= acc_reg + (XW'(prod_reg) << AW);
            end
            owvsr_pkg::ST_POST: begin
                if (phase_reg == owvsr_pkg::PH_SCALE) begin
                    dir_reg[idx_reg] <= !s_cur[SW-1] && (s_cur != '0) && !ms_zero;
                    on_reg[idx_reg]  <= (ms > {cfg.rate_floor, 8'h00});
                    if (ms_zero) begin
                        per_reg[idx_reg] <= 16'hFFFF;
                    end
                end else if (phase_reg == owvsr_pkg::PH_VEL) begin
                    vel_reg[idx_reg] <= v_cur[15] ? (~v_mag + 16'd1) : v_mag;
                end
            end
            owvsr_pkg::ST_DIV: begin
                if (div_done) begin
                    if (phase_reg == owvsr_pkg::PH_RATE) begin
                        m_reg[idx_reg] <= div_q;
                        maxm_reg       <= maxm_new;
                    end else begin
                        per_reg[idx_reg] <= per_sat;
                    end
                end
            end
            owvsr_pkg::ST_KDIV: begin
                if (div_done) begin
                    k_reg <= div_q[BW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // The finished command moves to the output bank so the next one can start.
    always_ff @(posedge aclk) begin
        if (state_reg == owvsr_pkg::ST_DONE && !ob_busy_reg) begin
            ob_per_reg <= per_reg;
            ob_dir_reg <= dir_reg;
            ob_on_reg  <= on_reg;
            ob_vel_reg <= vel_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_busy_reg <= 1'b0;
            ob_cnt_reg  <= '0;
        end else if (state_reg == owvsr_pkg::ST_DONE && !ob_busy_reg) begin
            ob_busy_reg <= 1'b1;
            ob_cnt_reg  <= '0;
        end else if (ob_busy_reg && m_ready) begin
            if (ob_cnt_reg == 2'd2) begin
                ob_busy_reg <= 1'b0;
                ob_cnt_reg  <= '0;
            end else begin
                ob_cnt_reg <= ob_cnt_reg + 2'd1;
            end
        end
    end

    always_comb begin
        case (ob_cnt_reg)
            2'd0:    m_driver_address = cfg.addr_front;
            2'd1:    m_driver_address = cfg.addr_left;
            default: m_driver_address = cfg.addr_right;
        endcase
    end

    assign m_valid          = ob_busy_reg;
    assign m_wheel_index    = ob_cnt_reg;
    assign m_step_period    = ob_per_reg[ob_cnt_reg];
    assign m_forward_dir    = ob_dir_reg[ob_cnt_reg];
    assign m_motor_on       = ob_on_reg[ob_cnt_reg];
    assign m_scaled_forward = ob_vel_reg[0];
    assign m_scaled_left    = ob_vel_reg[1];
    assign m_scaled_turn    = ob_vel_reg[2];
    assign m_last_wheel     = (ob_cnt_reg == 2'd2);

endmodule
`default_nettype wire

>>> rtl/core/omni_wheel_velocity_to_step_rate.sv
// Top level of the omni wheel velocity to step rate block.
// A body velocity command (forward, left, turn, signed fixed point) is taken in one
// transaction and yields three wheel result transactions, wheel 0 first. In the back
// stage, the shared divider resolves one quotient bit per cycle and runs up to seven
// 49-bit divisions per command (three wheel rates, the overspeed factor and three
// step periods); a stopped wheel skips its period division. A two-entry queue and a
// front register take further commands while one is in work, and finished results
// wait in an output bank while the next command starts. Configuration registers are
// written through cfg_we, cfg_index and cfg_wdata and must only change while no
// command is in flight.
`default_nettype none
module omni_wheel_velocity_to_step_rate #(
    parameter int TIMER_HZ      = owvsr_pkg::TIMER_HZ_DEF,
    parameter int VEL_FRAC_BITS = owvsr_pkg::VEL_FRAC_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_vel_forward,
    input  wire logic [15:0] s_vel_left,
    input  wire logic [15:0] s_turn_rate,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_wheel_index,
    output logic [7:0]       m_driver_address,
    output logic [15:0]      m_step_period,
    output logic             m_forward_dir,
    output logic             m_motor_on,
    output logic [15:0]      m_scaled_forward,
    output logic [15:0]      m_scaled_left,
    output logic [15:0]      m_scaled_turn,
    output logic             m_last_wheel
);
    owvsr_pkg::cfg_t cfg_reg;
    owvsr_pkg::cmd_t push_data;
    owvsr_pkg::cmd_t pop_data;
    logic            push_valid;
    logic            push_ready;
    logic            pop_valid;
    logic            pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= owvsr_pkg::CFG_RESET;
        end else if (cfg_we) begin
            case (owvsr_pkg::reg_idx_t'(cfg_index))
                owvsr_pkg::REG_HUB_DIST:         cfg_reg.hub_dist         <= cfg_wdata;
                owvsr_pkg::REG_TIRE_RAD:         cfg_reg.tire_rad         <= cfg_wdata;
                owvsr_pkg::REG_TICKS_PER_RADIAN: cfg_reg.ticks_per_radian <= cfg_wdata;
                owvsr_pkg::REG_RATE_LIMIT:       cfg_reg.rate_limit       <= cfg_wdata;
                owvsr_pkg::REG_RATE_FLOOR:       cfg_reg.rate_floor       <= cfg_wdata;
                owvsr_pkg::REG_ADDR_FRONT:       cfg_reg.addr_front       <= cfg_wdata[7:0];
                owvsr_pkg::REG_ADDR_LEFT:        cfg_reg.addr_left        <= cfg_wdata[7:0];
                owvsr_pkg::REG_ADDR_RIGHT:       cfg_reg.addr_right       <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    owvsr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vel_forward (s_vel_forward),
        .s_vel_left    (s_vel_left),
        .s_turn_rate   (s_turn_rate),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    owvsr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    owvsr_back #(
        .TIMER_HZ      (TIMER_HZ),
        .VEL_FRAC_BITS (VEL_FRAC_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .q_valid          (pop_valid),
        .q_ready          (pop_ready),
        .q_data           (pop_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_wheel_index    (m_wheel_index),
        .m_driver_address (m_driver_address),
        .m_step_period    (m_step_period),
        .m_forward_dir    (m_forward_dir),
        .m_motor_on       (m_motor_on),
        .m_scaled_forward (m_scaled_forward),
        .m_scaled_left    (m_scaled_left),
        .m_scaled_turn    (m_scaled_turn),
        .m_last_wheel     (m_last_wheel)
    );

`ifndef ASSERT_OFF
    // The remaining wheels of a command follow without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_wheel |=> m_valid)
        else $error("wheel results of one command were interrupted");

    // Wheel numbers step through the command in order.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_wheel |=> m_wheel_index == $past(m_wheel_index) + 2'd1)
        else $error("wheel index did not advance");

    // The last-wheel flag marks exactly wheel 2.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_wheel == (m_wheel_index == 2'd2)) && (m_wheel_index != 2'd3))
        else $error("last wheel flag disagrees with wheel index");

    // The scaled velocities stay fixed across the three results of a command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_wheel |=> $stable(m_scaled_forward)
            && $stable(m_scaled_left) && $stable(m_scaled_turn))
        else $error("scaled velocities changed within a command");
`endif

endmodule
`default_nettype wire
